### src/swa_pkg.sv
// Shared constants and controller/datapath interface types for the sliding window average.
package swa_pkg;

    localparam int DEF_WINDOW      = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int SAMPLE_PORT_BITS = 16;
    localparam int AVG_BITS         = 24;
    localparam int OLDEST_BITS      = 16;
    localparam int COUNT_BITS       = 5;
    localparam int FRAC_BITS        = 8;

    typedef struct packed {
        logic capture;    // latch the incoming sample
        logic rd_head;    // registered read of the slot at head
        logic update;     // write store, adjust sum, head and fill
        logic div_start;  // launch sum*256 / count
        logic load_out;   // move results into the output register
    } cmd_t;

    typedef struct packed {
        logic full;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

### src/swa_div.sv
// Iterative restoring divider: one quotient bit per cycle, signed dividend magnitude.
module swa_div #(
    parameter int QW = 29,
    parameter int CW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [QW-1:0] dividend,
    input  logic [CW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int NW = $clog2(QW + 1);

    logic [QW-1:0] dvd_reg;
    logic [QW-1:0] dvd_next;
    logic [CW:0]   rem_reg;
    logic [CW:0]   rem_next;
    logic [CW-1:0] dvs_reg;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic [CW:0]   rem_shift;

    assign rem_shift = {rem_reg[CW-1:0], dvd_reg[QW-1]};
    assign done      = busy_reg && (cnt_reg == NW'(1));
    assign quotient  = dvd_reg;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = NW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = rem_shift - {1'b0, dvs_reg};
                dvd_next = {dvd_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                dvd_next = {dvd_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - NW'(1);
            if (cnt_reg == NW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

endmodule

### src/swa_datapath.sv
// Datapath: ring store, running sum, head and fill tracking, divider and output register.
module swa_datapath #(
    parameter int WINDOW      = swa_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = swa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  swa_pkg::cmd_t                         cmd,
    output swa_pkg::status_t                      status,
    input  logic signed [swa_pkg::SAMPLE_PORT_BITS-1:0] sample,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [swa_pkg::AVG_BITS-1:0]    average_q8,
    output logic signed [swa_pkg::OLDEST_BITS-1:0] oldest,
    output logic [swa_pkg::COUNT_BITS-1:0]        count
);

    localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int SUMW = SAMPLE_BITS + CW;
    localparam int QW   = SUMW + swa_pkg::FRAC_BITS;

    logic [SAMPLE_BITS-1:0] mem [WINDOW];

    logic [SAMPLE_BITS-1:0] s_in;
    logic [SAMPLE_BITS-1:0] s_reg;
    logic [SAMPLE_BITS-1:0] rd_reg;
    logic [AW-1:0]          head_reg;
    logic [AW-1:0]          head_next;
    logic [CW-1:0]          fill_reg;
    logic [CW-1:0]          fill_next;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [SUMW-1:0] sum_next;
    logic [AW:0]            slot_raw;
    logic [AW-1:0]          waddr;
    logic                   full;
    logic                   neg;
    logic [SUMW-1:0]        mag;
    logic [QW-1:0]          quot;
    logic                   div_done;
    logic [QW-1:0]          avg_full;

    logic                                  result_valid_reg;
    logic signed [swa_pkg::AVG_BITS-1:0]    average_reg;
    logic signed [swa_pkg::OLDEST_BITS-1:0] oldest_reg;
    logic [swa_pkg::COUNT_BITS-1:0]        count_reg;

    // Sign comes from bit SAMPLE_BITS-1 of the port; wider samples see the port as unsigned.
    generate
        if (SAMPLE_BITS <= swa_pkg::SAMPLE_PORT_BITS)
        begin : g_narrow
            assign s_in = sample[SAMPLE_BITS-1:0];
        end
        else
        begin : g_wide
            assign s_in = SAMPLE_BITS'($unsigned(sample));
        end
    endgenerate

    assign full     = (fill_reg == CW'(WINDOW));
    assign slot_raw = (AW+1)'(head_reg) + (AW+1)'(fill_reg);
    assign waddr    = (slot_raw >= (AW+1)'(WINDOW)) ? AW'(slot_raw - (AW+1)'(WINDOW))
                                                    : AW'(slot_raw);

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg + SUMW'($signed(s_reg));
        if (full)
        begin
            sum_next  = sum_reg - SUMW'($signed(rd_reg)) + SUMW'($signed(s_reg));
            head_next = (head_reg == AW'(WINDOW - 1)) ? '0 : head_reg + AW'(1);
        end
        else
            fill_next = fill_reg + CW'(1);
    end

    // store: one write port at the insert slot, one registered read port at head
    always_ff @(posedge clk)
    begin
        if (cmd.update)
            mem[full ? head_reg : waddr] <= s_reg;
        if (cmd.rd_head)
            rd_reg <= mem[head_reg];
        if (cmd.capture)
            s_reg <= s_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.update)
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    assign neg = sum_reg[SUMW-1];
    assign mag = neg ? SUMW'(-sum_reg) : SUMW'(sum_reg);

    swa_div #(
        .QW (QW),
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({mag, {swa_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // sum is stable from div_start until the result is loaded
    assign avg_full = neg ? QW'(-quot) : quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.load_out)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            average_reg <= swa_pkg::AVG_BITS'($signed(avg_full));
            oldest_reg  <= swa_pkg::OLDEST_BITS'($signed(rd_reg));
            count_reg   <= swa_pkg::COUNT_BITS'(fill_reg);
        end
    end

    assign status.full     = full;
    assign status.div_done = div_done;
    assign status.out_free = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign average_q8   = average_reg;
    assign oldest       = oldest_reg;
    assign count        = count_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW))
        else $error("fill count exceeds window");

    a_head_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != '0) |-> full)
        else $error("head moved before window filled");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (fill_reg != '0))
        else $error("divide started with empty window");

    a_load_holds_sum: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> $stable(sum_reg))
        else $error("sum changed while result pending");
`endif

endmodule

### src/swa_ctrl.sv
// Controller: sequences capture, eviction read when full, store update, oldest read, divide and output load.
module swa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  swa_pkg::status_t status,
    output swa_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_UPDATE = 6'b000100,
        S_OLDEST = 6'b001000,
        S_DIV    = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = sample_valid;
                if (sample_valid)
                    state_next = status.full ? S_READ : S_UPDATE;
            end
            S_READ:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_OLDEST;
            end
            S_OLDEST:
            begin
                cmd.rd_head   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign sample_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTH
    a_read_before_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_UPDATE))
        else $error("eviction read not followed by update");

    a_start_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> $past(cmd.update))
        else $error("divide started without fresh sum");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_READ || state_reg == S_UPDATE))
        else $error("capture without entering update path");
`endif

endmodule

### src/sliding_window_average.sv
// Top level of the sliding window average: controller plus datapath.
// Usage:
//   Input channel sample/sample_valid/sample_ready carries one signed sample per beat.
//   Output channel result_valid/result_ready carries average_q8 (sum*256/count,
//   truncated toward zero), the oldest sample still held, and the count.
//   Every input beat produces exactly one output beat.
// Timing:
//   One sample at a time. An input beat is captured, then the store is read at
//   head for eviction when the window is already full, then the store is updated,
//   the oldest sample read and the divide started, then the result is loaded.
//   QW = SAMPLE_BITS + clog2(WINDOW+1) + 8 is the number of steps of the
//   restoring divider, 29 at the defaults; no new sample is accepted until the result of the last one has been loaded.
//   sample_ready returns high the cycle after the result is loaded.
// Reset:
//   rst_n clears sum, head, fill count and the output valid; store contents
//   are not cleared since only written slots are ever read.
// Stall:
//   A result waits in the output register while result_ready is low; the
//   next sample may be accepted and is processed, then holds before loading.
module sliding_window_average #(
    parameter int WINDOW      = swa_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = swa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        sample_valid,
    output logic                                        sample_ready,
    input  logic signed [swa_pkg::SAMPLE_PORT_BITS-1:0] sample,
    output logic                                        result_valid,
    input  logic                                        result_ready,
    output logic signed [swa_pkg::AVG_BITS-1:0]         average_q8,
    output logic signed [swa_pkg::OLDEST_BITS-1:0]      oldest,
    output logic [swa_pkg::COUNT_BITS-1:0]              count
);

    swa_pkg::cmd_t    cmd;
    swa_pkg::status_t status;

    swa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    swa_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .average_q8   (average_q8),
        .oldest       (oldest),
        .count        (count)
    );

endmodule
